// ===== hdl/skc_pkg.sv =====
// Shared constants, types and codes of the soft-knee compressor.
package skc_pkg;

	// sample format
	localparam int SW = 24;
	localparam int E_W = $clog2(SW);

	// iteration counts of the log and the knee divider
	localparam int LOG_STEPS = 16;
	localparam int DIV_STEPS = 15;
	localparam int CNT_W = $clog2(LOG_STEPS);

	// fixed-point conversion factors
	localparam int DB_PER_LOG2_Q16 = 394566;
	localparam int LOG2_PER_DB_Q24 = 2786635;
	localparam int FLOOR_DB_Q8 = 30720;

	// widths of the log and gain stages
	localparam int A_W = 21;
	localparam int P_W = 18;
	localparam int PM_W = P_W + SW;
	localparam int RES_W = PM_W + 16;
	localparam int SH_W = $clog2(PM_W);

	// register map
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_KNEE = 3'd1;
	localparam logic [2:0] REG_INV_RATIO = 3'd2;
	localparam logic [2:0] REG_ATTACK = 3'd3;
	localparam logic [2:0] REG_RELEASE = 3'd4;
	localparam logic [2:0] REG_MAKEUP = 3'd5;

	typedef struct packed {
		logic signed [15:0] threshold_db;
		logic [11:0] knee_width_db;
		logic [19:0] inverse_ratio;
		logic [15:0] attack_coef;
		logic [15:0] release_coef;
		logic signed [15:0] makeup_db;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MAG, ST_NORM, ST_LOG, ST_LVL, ST_LEVEL, ST_GAIN1, ST_GAIN2,
		ST_DIVSET, ST_DIV, ST_RED, ST_SM1, ST_SM2, ST_EXP1, ST_EXP2,
		ST_POLY1, ST_POLY2, ST_POLY3, ST_PMUL, ST_SHIFT, ST_PUSH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MAG, OP_NORM, OP_LOG, OP_LVL, OP_LEVEL, OP_GAIN1,
		OP_GAIN2, OP_DIVSET, OP_DIV, OP_RED, OP_SM1, OP_SM2, OP_EXP1, OP_EXP2,
		OP_POLY1, OP_POLY2, OP_POLY3, OP_PMUL, OP_SHIFT, OP_PUSH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage

// ===== hdl/soft_knee_audio_compressor_unit.sv =====
// Top level of the soft-knee compressor: register port, sequencer and datapath.
//
// Usage: samples enter on in_sample/in_valid/in_ready and leave on
// out_sample/out_valid/out_ready; a word moves when valid and ready are both
// high at a rising edge. One result word follows each input word, in order.
// The sequencer runs 16 squaring steps of the log, 15 steps of the knee divider
// and a handful of single multiply steps through one datapath. A new sample is
// accepted only once the previous result has been pushed to the output register.
// The result sits in an output register; while it waits the block finishes
// the next sample and then holds it until the register frees up.
// Registers (threshold, knee, inverse ratio, attack, release, makeup) sit at
// byte addresses 0 to 20 of the register port and should be written while
// the block is idle. Reset restores their defaults, clears the smoothed
// reduction and empties the output register.
module soft_knee_audio_compressor_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [skc_pkg::SW-1:0] in_sample,
	output logic out_valid,
	input logic out_ready,
	output logic signed [skc_pkg::SW-1:0] out_sample,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [skc_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import skc_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_db <= -16'sd5120;
			cfg_q.knee_width_db <= 12'd1536;
			cfg_q.inverse_ratio <= 20'd16384;
			cfg_q.attack_coef <= 16'd64000;
			cfg_q.release_coef <= 16'd65000;
			cfg_q.makeup_db <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_THRESHOLD: cfg_q.threshold_db <= $signed(pwdata[15:0]);
				REG_KNEE: cfg_q.knee_width_db <= pwdata[11:0];
				REG_INV_RATIO: cfg_q.inverse_ratio <= pwdata[19:0];
				REG_ATTACK: cfg_q.attack_coef <= pwdata[15:0];
				REG_RELEASE: cfg_q.release_coef <= pwdata[15:0];
				REG_MAKEUP: cfg_q.makeup_db <= $signed(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[4:2])
			REG_THRESHOLD: prdata = {16'b0, cfg_q.threshold_db};
			REG_KNEE: prdata = {20'b0, cfg_q.knee_width_db};
			REG_INV_RATIO: prdata = {12'b0, cfg_q.inverse_ratio};
			REG_ATTACK: prdata = {16'b0, cfg_q.attack_coef};
			REG_RELEASE: prdata = {16'b0, cfg_q.release_coef};
			REG_MAKEUP: prdata = {16'b0, cfg_q.makeup_db};
			default: prdata = '0;
		endcase
	end

	skc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	skc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg(cfg_q),
		.in_sample(in_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_sample(out_sample)
	);

endmodule

// ===== hdl/skc_ctrl.sv =====
// Sequencer of the compressor: steps the datapath through one sample.
module skc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input skc_pkg::sts_t sts,
	output skc_pkg::cmd_t cmd
);
	import skc_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// hold state and iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NORM) begin
				cnt_q <= CNT_W'(LOG_STEPS - 1);
			end else if (state_q == ST_DIVSET) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MAG;
			ST_MAG: state_d = ST_NORM;
			ST_NORM: state_d = ST_LOG;
			ST_LOG: if (cnt_q == '0) state_d = ST_LVL;
			ST_LVL: state_d = ST_LEVEL;
			ST_LEVEL: state_d = ST_GAIN1;
			ST_GAIN1: state_d = ST_GAIN2;
			ST_GAIN2: state_d = ST_DIVSET;
			ST_DIVSET: state_d = ST_DIV;
			ST_DIV: if (cnt_q == '0) state_d = ST_RED;
			ST_RED: state_d = ST_SM1;
			ST_SM1: state_d = ST_SM2;
			ST_SM2: state_d = ST_EXP1;
			ST_EXP1: state_d = ST_EXP2;
			ST_EXP2: state_d = ST_POLY1;
			ST_POLY1: state_d = ST_POLY2;
			ST_POLY2: state_d = ST_POLY3;
			ST_POLY3: state_d = ST_PMUL;
			ST_PMUL: state_d = ST_SHIFT;
			ST_SHIFT: state_d = ST_PUSH;
			ST_PUSH: if (!sts.out_full) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: if (in_valid) cmd.op = OP_LOAD;
			ST_MAG: cmd.op = OP_MAG;
			ST_NORM: cmd.op = OP_NORM;
			ST_LOG: cmd.op = OP_LOG;
			ST_LVL: cmd.op = OP_LVL;
			ST_LEVEL: cmd.op = OP_LEVEL;
			ST_GAIN1: cmd.op = OP_GAIN1;
			ST_GAIN2: cmd.op = OP_GAIN2;
			ST_DIVSET: cmd.op = OP_DIVSET;
			ST_DIV: cmd.op = OP_DIV;
			ST_RED: cmd.op = OP_RED;
			ST_SM1: cmd.op = OP_SM1;
			ST_SM2: cmd.op = OP_SM2;
			ST_EXP1: cmd.op = OP_EXP1;
			ST_EXP2: cmd.op = OP_EXP2;
			ST_POLY1: cmd.op = OP_POLY1;
			ST_POLY2: cmd.op = OP_POLY2;
			ST_POLY3: cmd.op = OP_POLY3;
			ST_PMUL: cmd.op = OP_PMUL;
			ST_SHIFT: cmd.op = OP_SHIFT;
			ST_PUSH: if (!sts.out_full) cmd.op = OP_PUSH;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== hdl/skc_dp.sv =====
// Datapath of the compressor: level, gain computer, smoother and gain stage.
module skc_dp (
	input logic clk,
	input logic arst_n,
	input skc_pkg::cmd_t cmd,
	output skc_pkg::sts_t sts,
	input skc_pkg::cfg_t cfg,
	input logic signed [skc_pkg::SW-1:0] in_sample,
	output logic out_valid,
	input logic out_ready,
	output logic signed [skc_pkg::SW-1:0] out_sample
);
	import skc_pkg::*;

	// payload registers
	logic [SW-1:0] sample_q, mag_q, res_q, out_sample_q;
	logic neg_q, zero_q, below_q, knee_q, tneg_q, out_valid_q;
	logic [E_W-1:0] e_q;
	logic [31:0] x_q;
	logic [15:0] frac_q, f_q;
	logic [39:0] lvlp_q;
	logic signed [17:0] d_q;
	logic signed [21:0] k_q;
	logic [25:0] qq_q;
	logic signed [39:0] lin_q;
	logic signed [47:0] t_q, lgp_q;
	logic [28:0] rem_q, ds_q;
	logic [14:0] quo_q;
	logic signed [23:0] r_q, red_q;
	logic signed [41:0] smp_q;
	logic signed [24:0] g_q;
	logic signed [16:0] n_q;
	logic [P_W-1:0] p_q;
	logic [PM_W-1:0] pm_q;

	// step values
	logic [SW-1:0] mag_c;
	logic [E_W-1:0] e_c;
	logic [31:0] x_c;
	logic [63:0] sq_c;
	logic [A_W-1:0] a_c;
	logic [40:0] dbs_c;
	logic [16:0] db_c, dbl_c;
	logic signed [17:0] xl_c, d_c;
	logic signed [18:0] d2_c, wv_c, q_c;
	logic below_c, knee_c;
	logic signed [21:0] k_c;
	logic [25:0] qq_c;
	logic signed [39:0] lin_c, lin_adj_c, lin_sh_c;
	logic signed [47:0] t_c, lgp_c;
	logic [47:0] tabs_c;
	logic ge_c;
	logic signed [23:0] qs_c, r_c;
	logic [15:0] c_c;
	logic signed [24:0] diff_c, g_c;
	logic signed [41:0] smp_c;
	logic signed [42:0] s_c, y_c;
	logic signed [48:0] ls_c;
	logic [P_W-1:0] pa_c, pbase_c, p_c;
	logic [P_W+15:0] pprod_c;
	logic [PM_W-1:0] pm_c, pt_c;
	logic signed [17:0] sft_c, sh_c, shm1_c;
	logic [RES_W-1:0] resw_c;
	logic [SW-1:0] lim_c, resc_c, out_c;

	// magnitude, leading one and normalized mantissa
	always_comb begin
		mag_c = sample_q[SW-1] ? (~sample_q + 1'b1) : sample_q;
		e_c = '0;
		for (int i = 0; i < SW; i++) begin
			if (mag_q[i]) e_c = E_W'(i);
		end
		x_c = 32'(mag_q) << (6'd31 - 6'(e_c));
		sq_c = 64'(x_q) * 64'(x_q);
		a_c = A_W'((A_W'(SW - 1) - A_W'(e_q)) << 16) - A_W'(frac_q);
	end

	// level in dB and distance to the threshold
	always_comb begin
		dbs_c = 41'(lvlp_q) + 41'(2 ** 23);
		db_c = dbs_c[40:24];
		dbl_c = (zero_q || db_c > 17'(FLOOR_DB_Q8)) ? 17'(FLOOR_DB_Q8) : db_c;
		xl_c = -$signed({1'b0, dbl_c});
		d_c = xl_c - $signed({{2{cfg.threshold_db[15]}}, cfg.threshold_db});
	end

	// knee and linear regions
	always_comb begin
		d2_c = $signed({d_q, 1'b0});
		wv_c = $signed({7'b0, cfg.knee_width_db});
		below_c = d2_c < -wv_c;
		knee_c = d2_c <= wv_c;
		q_c = d2_c + wv_c;
		qq_c = 26'(q_c[12:0]) * 26'(q_c[12:0]);
		k_c = 22'sd65536 - $signed({2'b0, cfg.inverse_ratio});
		lin_c = 40'(d_q) * 40'(k_c);
		t_c = 48'(k_q) * $signed({22'b0, qq_q});
		tabs_c = t_q[47] ? 48'(-t_q) : 48'(t_q);
		ge_c = rem_q >= ds_q;
	end

	// reduction select and smoother
	always_comb begin
		qs_c = $signed({9'b0, quo_q});
		lin_adj_c = lin_q[39] ? lin_q + 40'sd65535 : lin_q;
		lin_sh_c = lin_adj_c >>> 16;
		priority if (below_q || (knee_q && cfg.knee_width_db == '0)) begin
			r_c = '0;
		end else if (knee_q) begin
			r_c = tneg_q ? -qs_c : qs_c;
		end else begin
			r_c = lin_sh_c[23:0];
		end
		c_c = (r_q > red_q) ? cfg.attack_coef : cfg.release_coef;
		diff_c = 25'(red_q) - 25'(r_q);
		smp_c = $signed({26'b0, c_c}) * 42'(diff_c);
		s_c = (43'(r_q) <<< 16) + 43'(smp_q) + 43'sd32768;
		y_c = s_c >>> 16;
		g_c = 25'(cfg.makeup_db) - 25'($signed(y_c[23:0]));
	end

	// log2 gain, fraction polynomial and final scaling
	always_comb begin
		lgp_c = 48'(g_q) * 48'sd2786635;
		ls_c = 49'(lgp_q) + 49'sd32768;
		pa_c = (cmd.op == OP_POLY1) ? P_W'(5206) : p_q;
		unique case (cmd.op)
			OP_POLY1: pbase_c = P_W'(14713);
			OP_POLY2: pbase_c = P_W'(45617);
			default: pbase_c = P_W'(65536);
		endcase
		pprod_c = (P_W + 16)'(pa_c) * (P_W + 16)'(f_q);
		p_c = pbase_c + pprod_c[P_W+15:16];
		pm_c = PM_W'(p_q) * PM_W'(mag_q);
		sft_c = 18'(n_q) - 18'sd16;
		sh_c = -sft_c;
		shm1_c = sh_c - 18'sd1;
		pt_c = pm_q >> shm1_c[SH_W-1:0];
		lim_c = neg_q ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		priority if (pm_q == '0) begin
			resw_c = '0;
		end else if (sft_c >= 18'sd16) begin
			resw_c = RES_W'(lim_c);
		end else if (sft_c >= 18'sd0) begin
			resw_c = RES_W'(pm_q) << sft_c[3:0];
		end else if (sh_c > 18'(PM_W)) begin
			resw_c = '0;
		end else begin
			resw_c = RES_W'(pt_c >> 1) + RES_W'(pt_c[0]);
		end
		resc_c = (resw_c > RES_W'(lim_c)) ? lim_c : resw_c[SW-1:0];
		out_c = neg_q ? (~resc_c + 1'b1) : resc_c;
	end

	// advance the working registers by one step
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: sample_q <= in_sample;
			OP_MAG: begin
				neg_q <= sample_q[SW-1];
				mag_q <= mag_c;
			end
			OP_NORM: begin
				zero_q <= (mag_q == '0);
				e_q <= e_c;
				x_q <= x_c;
				frac_q <= '0;
			end
			OP_LOG: begin
				frac_q <= {frac_q[14:0], sq_c[63]};
				x_q <= sq_c[63] ? sq_c[63:32] : sq_c[62:31];
			end
			OP_LVL: lvlp_q <= 40'(a_c) * 40'(DB_PER_LOG2_Q16);
			OP_LEVEL: d_q <= d_c;
			OP_GAIN1: begin
				below_q <= below_c;
				knee_q <= knee_c;
				k_q <= k_c;
				qq_q <= qq_c;
				lin_q <= lin_c;
			end
			OP_GAIN2: t_q <= t_c;
			OP_DIVSET: begin
				tneg_q <= t_q[47];
				rem_q <= tabs_c[47:19];
				ds_q <= 29'(cfg.knee_width_db) << (DIV_STEPS - 1);
				quo_q <= '0;
			end
			OP_DIV: begin
				if (ge_c) rem_q <= rem_q - ds_q;
				quo_q <= {quo_q[13:0], ge_c};
				ds_q <= ds_q >> 1;
			end
			OP_RED: r_q <= r_c;
			OP_SM1: smp_q <= smp_c;
			OP_SM2: g_q <= g_c;
			OP_EXP1: lgp_q <= lgp_c;
			OP_EXP2: begin
				n_q <= ls_c[48:32];
				f_q <= ls_c[31:16];
			end
			OP_POLY1, OP_POLY2, OP_POLY3: p_q <= p_c;
			OP_PMUL: pm_q <= pm_c;
			OP_SHIFT: res_q <= out_c;
			OP_PUSH: out_sample_q <= res_q;
			default: ;
		endcase
	end

	// hold the smoothed reduction and the output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_SM2) red_q <= y_c[23:0];
			if (cmd.op == OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_full = out_valid_q & ~out_ready;
	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;

endmodule
